>>> rtl/core/cld_pkg.sv
// Shared types, constants and the key lookup for the content-length deframer.
// Depends on nothing; the top level and the cld_* submodules import it.
package cld_pkg;

  // Width of the parsed length, the body counter and the value accumulator
  localparam int LengthBits = 32;
  // Width of the limit register
  localparam int CfgBits    = 32;
  localparam int CmpBits    = (LengthBits > CfgBits) ? LengthBits : CfgBits;
  localparam int AccBits    = LengthBits + 4;

  localparam logic [CfgBits-1:0] MaxBodyReset = {CfgBits{1'b1}};

  // APB register map: one 32-bit register, index taken from paddr[2]
  localparam int ApbAddrBits = 3;
  localparam int ApbDataBits = 32;
  typedef enum logic [0:0] {
    RegMaxBodyLength = 1'b0
  } reg_idx_e;

  // Header key "Content-Length"
  localparam int KeyLen     = 14;
  localparam int KeyIdxBits = $clog2(KeyLen + 1);

  // Characters the parser looks for
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  typedef enum logic [1:0] {
    KindBody      = 2'd0,
    KindEmpty     = 2'd1,
    KindMalformed = 2'd2
  } result_kind_e;

  typedef enum logic [0:0] {
    PhHeader = 1'b0,
    PhBody   = 1'b1
  } phase_e;

  // Progress through CR LF CR LF
  typedef enum logic [1:0] {
    CrlfNone   = 2'd0,
    CrlfCr     = 2'd1,
    CrlfCrLf   = 2'd2,
    CrlfCrLfCr = 2'd3
  } crlf_e;

  typedef enum logic [1:0] {
    VpBlank  = 2'd0,
    VpSign   = 2'd1,
    VpDigits = 2'd2,
    VpDone   = 2'd3
  } value_phase_e;

  // One result as it travels from parser to output stage
  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   body_byte;
    logic         last;
  } result_t;

  // Parser status seen by the top level
  typedef struct packed {
    logic in_body;
    logic remain_zero;
  } front_status_t;

  // Result queue between parser and output stage
  localparam int QDepth     = 2;
  localparam int QPtrBits   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QLevelBits = $clog2(QDepth + 1);

  // Character of the key at a position below KeyLen
  function automatic logic [7:0] key_char(input logic [KeyIdxBits-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/cld_byte_if.sv
// Valid/ready channel carrying one raw stream byte per request.
// Depends on nothing.
interface cld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> rtl/core/cld_result_if.sv
// Valid/ready channel carrying one deframer result per request.
// Depends on nothing.
interface cld_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] body_byte;
  logic       last_of_frame;

  modport source (output valid, output result_kind, output body_byte,
                  output last_of_frame, input ready);
  modport sink   (input valid, input result_kind, input body_byte,
                  input last_of_frame, output ready);
endinterface

>>> rtl/core/content_length_deframer_top.sv
// Content-length deframer: with a free result channel, takes one stream
// byte per cycle and returns one result per cycle; a result is registered
// first in the queue and then in the output register. Header bytes give
// no result except the line end that closes the header, which gives an
// empty-frame or malformed result, or starts the body, whose bytes then
// pass through one per cycle, while the result channel is free, with the
// last one marked. The two-entry queue lets the byte side keep going while
// the result side stalls. max_body_length is read when a header closes;
// write it only while the block is idle.
// Depends on cld_pkg, cld_byte_if, cld_result_if and the cld_* submodules.
module content_length_deframer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cld_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [cld_pkg::ApbDataBits-1:0]  pwdata,
  output logic [cld_pkg::ApbDataBits-1:0]  prdata,
  output logic                             pready,
  cld_byte_if.sink                         byte_in,
  cld_result_if.source                     result_out
);
  import cld_pkg::*;

  logic [CfgBits-1:0]    max_body_length;
  logic                  q_push;
  result_t               q_push_data;
  logic                  q_pop;
  result_t               q_head;
  logic                  q_head_valid;
  logic                  q_full;
  logic [QLevelBits-1:0] q_level;
  front_status_t         front_status;

  // Configuration registers
  cld_cfg_regs u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_body_length_o (max_body_length)
  );

  // Header parser and body counter
  cld_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .byte_in           (byte_in),
    .max_body_length_i (max_body_length),
    .q_full_i          (q_full),
    .push_o            (q_push),
    .push_data_o       (q_push_data),
    .status_o          (front_status)
  );

  // Decoupling queue
  cld_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_push_data),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .head_valid_o (q_head_valid),
    .full_o       (q_full),
    .level_o      (q_level)
  );

  // Output stage
  cld_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_head_valid),
    .pop_o        (q_pop),
    .result_out   (result_out)
  );

`ifndef SYNTH
  // Frame results carry no byte and no last mark
  a_frame_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_out.valid && (result_out.result_kind != KindBody)) |->
      (!result_out.last_of_frame && (result_out.body_byte == 8'h00)))
    else $error("frame result carries body data");

  // A body in progress always has bytes left
  a_body_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_status.in_body |-> !front_status.remain_zero)
    else $error("body phase with nothing remaining");

  // The parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_level != QLevelBits'(QDepth)))
    else $error("result pushed into full queue");

  // A body byte marked last ends the body phase
  a_last_ends_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_push_data.last) |=> !front_status.in_body)
    else $error("body continues after last byte");
`endif

endmodule

>>> rtl/core/cld_cfg_regs.sv
// APB register file of the deframer: the body length limit.
// Depends on cld_pkg.
module cld_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cld_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [cld_pkg::ApbDataBits-1:0]  pwdata,
  output logic [cld_pkg::ApbDataBits-1:0]  prdata,
  output logic                             pready,
  output logic [cld_pkg::CfgBits-1:0]      max_body_length_o
);
  import cld_pkg::*;

  logic [CfgBits-1:0] max_len_q;
  logic [CfgBits-1:0] max_len_d;
  reg_idx_e           reg_idx;
  logic               wr_en;

  // Decode the register index from the word address
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Take a write in the access phase
  always_comb begin
    max_len_d = max_len_q;
    if (wr_en && reg_idx == RegMaxBodyLength) begin
      max_len_d = pwdata[CfgBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxBodyReset;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_idx)
      RegMaxBodyLength: prdata = ApbDataBits'(max_len_q);
      default:          prdata = '0;
    endcase
  end

  assign max_body_length_o = max_len_q;

endmodule

>>> rtl/core/cld_parser.sv
// Front end of the deframer: takes stream bytes, parses the header block and
// emits body bytes or frame results towards the queue. Depends on cld_pkg.
module cld_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cld_byte_if.sink                     byte_in,
  input  logic [cld_pkg::CfgBits-1:0]  max_body_length_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output cld_pkg::result_t             push_data_o,
  output cld_pkg::front_status_t       status_o
);
  import cld_pkg::*;

  phase_e                  phase_q, phase_d;
  crlf_e                   crlf_q, crlf_d;
  logic [KeyIdxBits-1:0]   key_idx_q, key_idx_d;
  logic                    key_mis_q, key_mis_d;
  logic                    colon_q, colon_d;
  value_phase_e            vphase_q, vphase_d;
  logic [LengthBits-1:0]   acc_q, acc_d;
  logic                    dig_q, dig_d;
  logic                    neg_q, neg_d;
  logic                    ovf_q, ovf_d;
  logic                    len_valid_q, len_valid_d;
  logic [LengthBits-1:0]   len_q, len_d;
  logic [LengthBits-1:0]   remain_q, remain_d;

  logic                    accept;
  logic [7:0]              b;
  logic                    is_digit;
  logic                    is_blank;
  logic                    is_sign;
  logic [AccBits-1:0]      acc_next;
  logic                    acc_ovf;
  logic                    value_ok;
  logic [LengthBits-1:0]   remain_dec;

  // Stall only when the queue cannot take a result
  assign byte_in.ready = !q_full_i;
  assign accept        = byte_in.valid && byte_in.ready;
  assign b             = byte_in.stream_byte;

  // Classify the byte
  assign is_digit = (b >= Ch0) && (b <= Ch9);
  assign is_blank = (b == ChSpace) || (b == ChTab);
  assign is_sign  = (b == ChPlus) || (b == ChMinus);

  // Accumulate acc * 10 + digit; the low nibble of an ASCII digit is its value
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + AccBits'(b[3:0]);
  assign acc_ovf  = |acc_next[AccBits-1:LengthBits];
  assign value_ok = dig_q && !ovf_q && !(neg_q && (acc_q != '0));

  assign remain_dec = remain_q - LengthBits'(1);

  // Next state and pushed result
  always_comb begin
    logic                  lv_fin;
    logic [LengthBits-1:0] len_fin;
    lv_fin      = len_valid_q;
    len_fin     = len_q;
    phase_d     = phase_q;
    crlf_d      = crlf_q;
    key_idx_d   = key_idx_q;
    key_mis_d   = key_mis_q;
    colon_d     = colon_q;
    vphase_d    = vphase_q;
    acc_d       = acc_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    len_valid_d = len_valid_q;
    len_d       = len_q;
    remain_d    = remain_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KindBody, body_byte: 8'h00, last: 1'b0};

    if (accept) begin
      if (phase_q == PhBody) begin
        // Pass a body byte, mark the last one
        remain_d              = remain_dec;
        push_o                = 1'b1;
        push_data_o.body_byte = b;
        push_data_o.last      = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_d = PhHeader;
          crlf_d  = CrlfNone;
        end
      end else if (b == ChLf && (crlf_q == CrlfCr || crlf_q == CrlfCrLfCr)) begin
        // Finish the line; a matching key replaces the latched length
        if (colon_q && !key_mis_q) begin
          lv_fin  = value_ok;
          len_fin = value_ok ? acc_q : '0;
        end
        key_idx_d = '0;
        key_mis_d = 1'b0;
        colon_d   = 1'b0;
        vphase_d  = VpBlank;
        acc_d     = '0;
        dig_d     = 1'b0;
        neg_d     = 1'b0;
        ovf_d     = 1'b0;
        if (crlf_q == CrlfCr) begin
          crlf_d      = CrlfCrLf;
          len_valid_d = lv_fin;
          len_d       = len_fin;
        end else begin
          // Header closed: check the length and start the body or report
          crlf_d      = CrlfNone;
          len_valid_d = 1'b0;
          len_d       = '0;
          push_o      = 1'b1;
          if (!lv_fin || (CmpBits'(len_fin) > CmpBits'(max_body_length_i))) begin
            push_data_o.kind = KindMalformed;
          end else if (len_fin == '0) begin
            push_data_o.kind = KindEmpty;
          end else begin
            push_o   = 1'b0;
            phase_d  = PhBody;
            remain_d = len_fin;
          end
        end
      end else begin
        // Track CR LF CR LF
        if (b == ChCr) begin
          crlf_d = (crlf_q == CrlfCrLf) ? CrlfCrLfCr : CrlfCr;
        end else begin
          crlf_d = CrlfNone;
        end
        // Feed the line parser
        if (!colon_q) begin
          if (b == ChColon) begin
            colon_d = 1'b1;
            if (key_idx_q != KeyIdxBits'(KeyLen)) begin
              key_mis_d = 1'b1;
            end
          end else if (!key_mis_q && (key_idx_q < KeyIdxBits'(KeyLen)) &&
                       (b == key_char(key_idx_q))) begin
            key_idx_d = key_idx_q + KeyIdxBits'(1);
          end else begin
            key_mis_d = 1'b1;
          end
        end else if (!key_mis_q && vphase_q != VpDone) begin
          if (is_digit) begin
            if (!ovf_q) begin
              if (acc_ovf) begin
                ovf_d = 1'b1;
              end else begin
                acc_d = acc_next[LengthBits-1:0];
              end
            end
            dig_d    = 1'b1;
            vphase_d = VpDigits;
          end else if (vphase_q == VpBlank && is_blank) begin
            vphase_d = VpBlank;
          end else if (vphase_q == VpBlank && is_sign) begin
            neg_d    = (b == ChMinus);
            vphase_d = VpSign;
          end else begin
            vphase_d = VpDone;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      crlf_q      <= CrlfNone;
      key_idx_q   <= '0;
      key_mis_q   <= 1'b0;
      colon_q     <= 1'b0;
      vphase_q    <= VpBlank;
      acc_q       <= '0;
      dig_q       <= 1'b0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      len_valid_q <= 1'b0;
      len_q       <= '0;
      remain_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      crlf_q      <= crlf_d;
      key_idx_q   <= key_idx_d;
      key_mis_q   <= key_mis_d;
      colon_q     <= colon_d;
      vphase_q    <= vphase_d;
      acc_q       <= acc_d;
      dig_q       <= dig_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      len_valid_q <= len_valid_d;
      len_q       <= len_d;
      remain_q    <= remain_d;
    end
  end

  assign status_o.in_body     = (phase_q == PhBody);
  assign status_o.remain_zero = (remain_q == '0);

endmodule

>>> rtl/core/cld_queue.sv
// Short result queue between the parser and the output stage.
// Depends on cld_pkg.
module cld_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  cld_pkg::result_t                   push_data_i,
  input  logic                               pop_i,
  output cld_pkg::result_t                   head_o,
  output logic                               head_valid_o,
  output logic                               full_o,
  output logic [cld_pkg::QLevelBits-1:0]     level_o
);
  import cld_pkg::*;

  result_t               entry_q [QDepth];
  logic [QPtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QLevelBits-1:0] level_q, level_d;
  logic                  do_push;
  logic                  do_pop;

  assign head_valid_o = (level_q != '0);
  assign full_o       = (level_q == QLevelBits'(QDepth));
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;
  assign head_o       = entry_q[rd_ptr_q];
  assign level_o      = level_q;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrBits'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrBits'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrBits'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + QLevelBits'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - QLevelBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Store the pushed result
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/cld_emit.sv
// Back end of the deframer: pulls results from the queue into the output
// register and presents them on the result channel. Depends on cld_pkg.
module cld_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cld_pkg::result_t  head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  cld_result_if.source      result_out
);
  import cld_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t out_data_q;
  logic    load;

  // Load when the register is empty or being taken
  assign load  = head_valid_i && (!out_valid_q || result_out.ready);
  assign pop_o = load;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (result_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= head_i;
    end
  end

  assign result_out.valid         = out_valid_q;
  assign result_out.result_kind   = out_data_q.kind;
  assign result_out.body_byte     = out_data_q.body_byte;
  assign result_out.last_of_frame = out_data_q.last;

endmodule
